### hdl/gcc_pkg.sv
package gcc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_IN_BASE  = 3'd0;
	localparam logic [2:0] REG_IN_SCALE = 3'd1;
	localparam logic [2:0] REG_OUT_BASE = 3'd2;
	localparam logic [2:0] REG_OUT_SPAN = 3'd3;
	localparam logic [2:0] REG_GAMMA    = 3'd4;

	localparam longint unsigned ONE30 = 64'd1 << 30;
	localparam longint unsigned TWO30 = 64'd1 << 31;

	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	typedef logic [31:0] word_t;

	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned vv;
		res  = 0;
		bitv = 64'd1 << 62;
		vv   = v;
		for (int j = 0; j < 32; j++) begin
			if (vv >= res + bitv) begin
				vv  = vv - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// log2(1 + i/2^bits) in Q30, by repeated squaring
	function automatic word_t log_entry(input int unsigned i, input int unsigned bits);
		longint unsigned x;
		word_t r;
		r = '0;
		if (i == (32'd1 << bits))
			return word_t'(ONE30);
		x = ONE30 + (longint'(i) << (30 - bits));
		for (int k = 1; k <= 30; k++) begin
			x = (x * x) >> 30;
			if (x >= TWO30) begin
				x = x >> 1;
				r[30-k] = 1'b1;
			end
		end
		return r;
	endfunction

	// 2^(i/2^bits) in Q30 as a product of square roots of two
	function automatic word_t exp_entry(input int unsigned i, input int unsigned bits);
		longint unsigned root [0:12];
		longint unsigned acc;
		for (int k = 0; k <= 12; k++)
			root[k] = 0;
		if (i == (32'd1 << bits))
			return word_t'(TWO30);
		root[0] = TWO30;
		for (int k = 1; k <= 12; k++)
			if (k <= bits)
				root[k] = isqrt64(root[k-1] << 30);
		acc = ONE30;
		for (int k = 0; k < 12; k++)
			if (k < bits && ((i >> k) & 1) != 0)
				acc = (acc * root[bits-k]) >> 30;
		return word_t'(acc);
	endfunction

endpackage

### hdl/gcc_ifs.sv
interface gcc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] control_value;

	modport source(output valid, output control_value, input ready);
	modport sink(input valid, input control_value, output ready);
endinterface

interface gcc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mapped_value;
	logic               saturated;

	modport source(output valid, output mapped_value, output saturated, input ready);
	modport sink(input valid, input mapped_value, input saturated, output ready);
endinterface

### hdl/gamma_control_curve.sv
// Channel  | Dir | Payload                          | Transaction
// in_ch    | in  | control_value  s32 Q16.16        | valid & ready
// out_ch   | out | mapped_value s32, saturated 1b  | valid & ready
// cfg      | in  | cfg_index 3b, cfg_data 32b       | cfg_we
//
// Twelve cells deep: a transaction on in_ch passes every cell, from scale to the output register, before out_ch.
// One transaction per cycle is taken; the whole row advances together and
// holds while the final cell carries an untaken result.
// arst_n clears all valid flags and loads the register reset values.
// Payload cells carry no reset.
module gamma_control_curve #(
	parameter int LOG_TABLE_BITS = 8,
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	gcc_in_if.sink      in_ch,
	gcc_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  gcc_pkg::word_t cfg_data
);
	import gcc_pkg::*;

	localparam int LFW      = 30 - LOG_TABLE_BITS;   // log interpolation bits
	localparam int EFW      = 30 - EXP_TABLE_BITS;   // exp interpolation bits
	localparam int LOG_SIZE = (1 << LOG_TABLE_BITS) + 1;
	localparam int EXP_SIZE = (1 << EXP_TABLE_BITS) + 1;
	localparam int NCELL    = 12;

	// ---------------- configuration registers ----------------
	logic signed [31:0] in_base_q, in_scale_q, out_base_q, out_span_q;
	logic        [23:0] gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= 32'sd0;
			in_scale_q <= 32'sd65536;
			out_base_q <= 32'sd0;
			out_span_q <= 32'sd65536;
			gamma_q    <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_BASE:  in_base_q  <= cfg_data;
				REG_IN_SCALE: in_scale_q <= cfg_data;
				REG_OUT_BASE: out_base_q <= cfg_data;
				REG_OUT_SPAN: out_span_q <= cfg_data;
				REG_GAMMA:    gamma_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// ---------------- curve tables (constants) ----------------
	word_t log_tab [0:LOG_SIZE-1];
	word_t exp_tab [0:EXP_SIZE-1];

	for (genvar g = 0; g < LOG_SIZE; g++) begin : g_log
		assign log_tab[g] = log_entry(g, LOG_TABLE_BITS);
	end
	for (genvar g = 0; g < EXP_SIZE; g++) begin : g_exp
		assign exp_tab[g] = exp_entry(g, EXP_TABLE_BITS);
	end

	// the row moves whenever the last cell is empty or being drained
	logic adv;
	logic [NCELL-1:0] v;
	assign adv         = !v[NCELL-1] || out_ch.ready;
	assign in_ch.ready = adv;

	// ---------------- cell 1: scale ----------------
	logic signed [32:0] d_c0;
	logic signed [64:0] m_c0, m_s1;
	assign d_c0 = 33'(in_ch.control_value) - 33'(in_base_q);
	assign m_c0 = 65'(in_scale_q) * 65'(d_c0);

	gcc_cell #(.W(65)) u_c1 (.clk, .arst_n, .en(adv), .vin(in_ch.valid),
		.din(m_c0), .vout(v[0]), .dout(m_s1));

	// ---------------- cell 2: clamp to t ----------------
	logic [46:0] t_c1, t_s2;
	assign t_c1 = m_s1[64] ? '0 : m_s1[62:16];

	gcc_cell #(.W(47)) u_c2 (.clk, .arst_n, .en(adv), .vin(v[0]),
		.din(t_c1), .vout(v[1]), .dout(t_s2));

	// ---------------- cell 3: leading one ----------------
	logic [5:0] k_c2, k_s3;
	logic       z_c2, z_s3;
	logic [46:0] t_s3;

	always_comb begin
		k_c2 = '0;
		for (int i = 0; i < 47; i++)
			if (t_s2[i])
				k_c2 = 6'(i);
		z_c2 = (t_s2 == '0);
	end

	gcc_cell #(.W(54)) u_c3 (.clk, .arst_n, .en(adv), .vin(v[1]),
		.din({k_c2, t_s2, z_c2}), .vout(v[2]), .dout({k_s3, t_s3, z_s3}));

	// ---------------- cell 4: normalize, log table ----------------
	logic [76:0]               wide_c3;
	logic [29:0]               f_c3;
	logic [LOG_TABLE_BITS-1:0] lidx_c3;
	logic [LOG_TABLE_BITS:0]   lia_c3, lib_c3;
	logic [31:0]               la_c3, la_s4;
	logic signed [31:0]        ld_c3, ld_s4;
	logic [LFW-1:0]            lfrac_s4;
	logic [5:0]                k_s4;
	logic                      z_s4;

	assign wide_c3 = {t_s3, 30'b0} >> k_s3;      // mantissa in Q30
	assign f_c3    = wide_c3[29:0];
	assign lidx_c3 = f_c3[29 -: LOG_TABLE_BITS];
	assign lia_c3  = {1'b0, lidx_c3};
	assign lib_c3  = lia_c3 + 1'b1;
	assign la_c3   = log_tab[lia_c3];
	assign ld_c3   = $signed(log_tab[lib_c3]) - $signed(log_tab[lia_c3]);

	gcc_cell #(.W(71 + LFW)) u_c4 (.clk, .arst_n, .en(adv), .vin(v[2]),
		.din({la_c3, ld_c3, f_c3[LFW-1:0], k_s3, z_s3}), .vout(v[3]),
		.dout({la_s4, ld_s4, lfrac_s4, k_s4, z_s4}));

	// ---------------- cell 5: log interpolation ----------------
	logic signed [LFW+32:0] lmul_c4, lsh_c4;
	logic signed [6:0]      kk_c4;
	logic signed [36:0]     lg_c4, lg_s5;
	logic                   z_s5;

	assign lmul_c4 = ld_s4 * $signed({1'b0, lfrac_s4});
	assign lsh_c4  = lmul_c4 >>> LFW;
	assign kk_c4   = $signed({1'b0, k_s4}) - 7'sd16;
	assign lg_c4   = $signed({kk_c4, 30'b0}) + $signed({5'b0, la_s4}) + 37'(lsh_c4);

	gcc_cell #(.W(38)) u_c5 (.clk, .arst_n, .en(adv), .vin(v[3]),
		.din({lg_c4, z_s4}), .vout(v[4]), .dout({lg_s5, z_s5}));

	// ---------------- cell 6: times gamma ----------------
	logic signed [61:0] gp_c5;
	logic signed [45:0] y_s6;
	logic               z_s6;

	assign gp_c5 = $signed({1'b0, gamma_q}) * lg_s5;

	gcc_cell #(.W(47)) u_c6 (.clk, .arst_n, .en(adv), .vin(v[4]),
		.din({gp_c5[61:16], z_s5}), .vout(v[5]), .dout({y_s6, z_s6}));

	// ---------------- cell 7: exp table ----------------
	logic [EXP_TABLE_BITS-1:0] eidx_c6;
	logic [EXP_TABLE_BITS:0]   eia_c6, eib_c6;
	logic [31:0]               ea_s7;
	logic signed [32:0]        ed_c6, ed_s7;
	logic [EFW-1:0]            efrac_s7;
	logic signed [15:0]        n_s7;
	logic                      z_s7;

	assign eidx_c6 = y_s6[29 -: EXP_TABLE_BITS];
	assign eia_c6  = {1'b0, eidx_c6};
	assign eib_c6  = eia_c6 + 1'b1;
	assign ed_c6   = $signed({1'b0, exp_tab[eib_c6]}) - $signed({1'b0, exp_tab[eia_c6]});

	gcc_cell #(.W(82 + EFW)) u_c7 (.clk, .arst_n, .en(adv), .vin(v[5]),
		.din({exp_tab[eia_c6], ed_c6, y_s6[EFW-1:0], y_s6[45:30], z_s6}),
		.vout(v[6]), .dout({ea_s7, ed_s7, efrac_s7, n_s7, z_s7}));

	// ---------------- cell 8: exp interpolation ----------------
	logic signed [EFW+33:0] emul_c7, esh_c7;
	logic signed [33:0]     msum_c7;
	logic [31:0]            m_s8;
	logic signed [15:0]     n_s8;
	logic                   z_s8;

	assign emul_c7 = ed_s7 * $signed({1'b0, efrac_s7});
	assign esh_c7  = emul_c7 >>> EFW;
	assign msum_c7 = $signed({2'b0, ea_s7}) + 34'(esh_c7);

	gcc_cell #(.W(49)) u_c8 (.clk, .arst_n, .en(adv), .vin(v[6]),
		.din({msum_c7[31:0], n_s7, z_s7}), .vout(v[7]), .dout({m_s8, n_s8, z_s8}));

	// ---------------- cell 9: scale by 2^n ----------------
	logic [50:0]        p_c8, p_s9;
	logic signed [15:0] nl_c8, nr_c8;

	always_comb begin
		nl_c8 = n_s8 - 16'sd14;
		nr_c8 = 16'sd14 - n_s8;
		if (z_s8)
			p_c8 = (gamma_q == '0) ? 51'd65536 : '0;
		else if (n_s8 > 16'sd32)
			p_c8 = 51'd1 << 50;                  // huge power
		else if (n_s8 >= 16'sd14)
			p_c8 = {19'b0, m_s8} << nl_c8[4:0];
		else if (nr_c8 >= 16'sd64)
			p_c8 = '0;                           // tiny power
		else
			p_c8 = {19'b0, m_s8} >> nr_c8[5:0];
	end

	gcc_cell #(.W(51)) u_c9 (.clk, .arst_n, .en(adv), .vin(v[7]),
		.din(p_c8), .vout(v[8]), .dout(p_s9));

	// ---------------- cell 10: partial products with |span| ----------------
	logic [31:0] mag_c9;
	logic [57:0] pph_c9, pph_s10;
	logic [56:0] ppl_c9, ppl_s10;

	assign mag_c9 = out_span_q[31] ? 32'(-out_span_q) : out_span_q;
	assign pph_c9 = {32'b0, p_s9[50:25]} * {26'b0, mag_c9};
	assign ppl_c9 = {32'b0, p_s9[24:0]} * {25'b0, mag_c9};

	gcc_cell #(.W(115)) u_c10 (.clk, .arst_n, .en(adv), .vin(v[8]),
		.din({pph_c9, ppl_c9}), .vout(v[9]), .dout({pph_s10, ppl_s10}));

	// ---------------- cell 11: sum and range check ----------------
	logic [82:0] prod_c10;
	logic        over_c10, over_s11;
	logic [49:0] prod_s11;

	assign prod_c10 = {pph_s10, 25'b0} + {26'b0, ppl_s10};
	assign over_c10 = prod_c10 > (83'd1 << 49);

	gcc_cell #(.W(51)) u_c11 (.clk, .arst_n, .en(adv), .vin(v[9]),
		.din({prod_c10[49:0], over_c10}), .vout(v[10]), .dout({prod_s11, over_s11}));

	// ---------------- cell 12: add base, clamp (output register) ----------------
	logic [50:0]        nsum_c11;
	logic signed [35:0] q_c11, r_c11;
	logic signed [31:0] res_c11;
	logic               sat_c11;
	logic [32:0]        out_s12;

	always_comb begin
		nsum_c11 = {1'b0, prod_s11} + 51'hFFFF;   // round toward minus infinity
		if (out_span_q[31])
			q_c11 = -$signed({2'b0, nsum_c11[49:16]});
		else
			q_c11 = $signed({2'b0, prod_s11[49:16]});
		r_c11   = 36'(out_base_q) + q_c11;
		sat_c11 = 1'b0;
		res_c11 = r_c11[31:0];
		if (over_s11) begin
			sat_c11 = 1'b1;
			res_c11 = out_span_q[31] ? INT32_MIN : INT32_MAX;
		end else if (r_c11 > 36'(INT32_MAX)) begin
			sat_c11 = 1'b1;
			res_c11 = INT32_MAX;
		end else if (r_c11 < 36'(INT32_MIN)) begin
			sat_c11 = 1'b1;
			res_c11 = INT32_MIN;
		end
	end

	gcc_cell #(.W(33)) u_c12 (.clk, .arst_n, .en(adv), .vin(v[10]),
		.din({res_c11, sat_c11}), .vout(v[11]), .dout(out_s12));

	assign out_ch.valid        = v[NCELL-1];
	assign out_ch.mapped_value = out_s12[32:1];
	assign out_ch.saturated    = out_s12[0];
endmodule

### hdl/gcc_cell.sv
// one pipeline slot: valid flag plus payload, moves when en is high
module gcc_cell #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vin,
	input  logic [W-1:0] din,
	output logic         vout,
	output logic [W-1:0] dout
);
	logic         valid_q;
	logic [W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= din;
		end
	end

	assign vout = valid_q;
	assign dout = data_q;
endmodule

### hdl/gcc_checker.sv
module gcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] mapped_value,
	input logic        saturated
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mapped_value) && $stable(saturated))
		else $error("result changed while stalled");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while row is stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			mapped_value == 32'h7FFF_FFFF || mapped_value == 32'h8000_0000)
		else $error("saturated result off the rails");
endmodule

bind gamma_control_curve gcc_checker u_gcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.mapped_value (out_ch.mapped_value),
	.saturated    (out_ch.saturated)
);

### tb/sv/gamma_control_curve_test.sv
`timescale 1ns / 100ps

module gamma_control_curve_test;
	import gcc_pkg::*;

	// table geometry matches the block's defaults
	localparam int LOG_BITS = 8;
	localparam int EXP_BITS = 8;
	localparam int LOG_SHIFT = 30 - LOG_BITS;
	localparam int EXP_SHIFT = 30 - EXP_BITS;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned Q30_TWO = 64'd1 << 31;
	// index past the register file, the write must be dropped
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int LATENCY_WAIT = 24;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [31:0] mapped_value;
		logic               saturated;
	} curve_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	word_t       cfg_data;

	gcc_in_if  in_ch();
	gcc_out_if out_ch();

	gamma_control_curve dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the curve registers, reset values
	logic signed [31:0] sh_in_base  = 0;
	logic signed [31:0] sh_in_scale = 65536;
	logic signed [31:0] sh_out_base = 0;
	logic signed [31:0] sh_out_span = 65536;
	logic [23:0]        sh_gamma    = 24'd65536;

	// log2 and exp2 mantissa tables in Q30
	longint unsigned log2_tab [0:(1<<LOG_BITS)];
	longint unsigned exp2_tab [0:(1<<EXP_BITS)];

	logic signed [31:0] pending_q [$];
	curve_out_t         curve_q [$];

	int   errors = 0;
	int   n_taken = 0;
	int   n_checked = 0;
	int   n_sat = 0;
	int   stall_cnt = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   hold_cnt = 0;
	bit   in_taken = 0;
	bit   hold_req = 0;
	bit   hold_done = 0;
	bit   calm = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void fill_tables();
		longint unsigned x;
		longint unsigned acc;
		longint unsigned roots [0:EXP_BITS];
		longint unsigned r;
		for (int i = 0; i < (1 << LOG_BITS); i++) begin
			x = Q30_ONE + (longint'(i) << LOG_SHIFT);
			r = 0;
			// one result bit per squaring round
			for (int k = 1; k <= 30; k++) begin
				x = (x * x) >> 30;
				if (x >= Q30_TWO) begin
					x = x >> 1;
					r = r | (64'd1 << (30 - k));
				end
			end
			log2_tab[i] = r;
		end
		log2_tab[1 << LOG_BITS] = Q30_ONE;
		roots[0] = Q30_TWO;
		for (int k = 1; k <= EXP_BITS; k++)
			roots[k] = int_sqrt(roots[k-1] << 30);
		for (int i = 0; i < (1 << EXP_BITS); i++) begin
			acc = Q30_ONE;
			for (int k = 0; k < EXP_BITS; k++)
				if (((i >> k) & 1) != 0)
					acc = (acc * roots[EXP_BITS - k]) >> 30;
			exp2_tab[i] = acc;
		end
		exp2_tab[1 << EXP_BITS] = Q30_TWO;
	endfunction

	function automatic longint lerp(input longint unsigned a, input longint unsigned b,
			input longint unsigned frac, input int s);
		longint diff;
		diff = longint'(b) - longint'(a);
		return longint'(a) + ((diff * longint'(frac)) >>> s);
	endfunction

	// t^gamma in Q16.16, t in Q16.16
	function automatic longint unsigned curve_power(input longint unsigned t);
		int k;
		longint unsigned mant;
		longint unsigned f;
		longint unsigned idx;
		longint lg;
		longint y;
		longint n;
		longint fr;
		longint m;
		if (t == 0)
			return (sh_gamma == 0) ? 64'd65536 : 64'd0;
		k = 63;
		while (k > 0 && t[k] == 1'b0)
			k--;
		mant = (k <= 30) ? (t << (30 - k)) : (t >> (k - 30));
		f = mant - Q30_ONE;
		idx = f >> LOG_SHIFT;
		lg = longint'(k - 16) * longint'(Q30_ONE)
			+ lerp(log2_tab[idx], log2_tab[idx+1], f & ((64'd1 << LOG_SHIFT) - 1), LOG_SHIFT);
		y = (longint'({40'd0, sh_gamma}) * lg) >>> 16;
		n = y >>> 30;
		fr = y - n * longint'(Q30_ONE);
		idx = longint'(fr) >> EXP_SHIFT;
		m = lerp(exp2_tab[idx], exp2_tab[idx+1],
			longint'(fr) & ((64'd1 << EXP_SHIFT) - 1), EXP_SHIFT);
		// huge power: beyond any product we can represent
		if (n > 32)
			return 64'd1 << 50;
		if (n >= 14)
			return longint'(m) << (n - 14);
		if (14 - n >= 64)
			return 0;
		return longint'(m) >> (14 - n);
	endfunction

	function automatic curve_out_t map_control(input logic signed [31:0] cv);
		curve_out_t res;
		longint d;
		longint prod_s;
		longint q;
		longint r;
		longint unsigned t;
		longint unsigned p;
		longint unsigned mag;
		bit sat;
		d = longint'(cv) - longint'(sh_in_base);
		prod_s = longint'(sh_in_scale) * d;
		// negative t clamps to zero
		t = (prod_s < 0) ? 64'd0 : (longint'(prod_s) >> 16);
		p = curve_power(t);
		q = 0;
		r = 0;
		sat = 0;
		// zero span leaves out_base even for a huge power
		if (sh_out_span != 0) begin
			mag = (sh_out_span < 0) ? longint'(-longint'(sh_out_span)) : longint'(sh_out_span);
			if (p > (64'd1 << 49) / mag) begin
				sat = 1;
				r = (sh_out_span > 0) ? longint'(INT32_MAX) : longint'(INT32_MIN);
			end else if (sh_out_span > 0) begin
				q = longint'((p * mag) >> 16);
			end else begin
				q = -longint'((p * mag + 64'hFFFF) >> 16);
			end
		end
		if (!sat) begin
			r = longint'(sh_out_base) + q;
			if (r > longint'(INT32_MAX)) begin
				r = INT32_MAX;
				sat = 1;
			end
			if (r < longint'(INT32_MIN)) begin
				r = INT32_MIN;
				sat = 1;
			end
		end
		res.mapped_value = r[31:0];
		res.saturated = sat;
		return res;
	endfunction

	// input side: offers pending values, random gaps unless calm
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 16);
				in_ch.valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.control_value <= pending_q.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output side: random stall bursts, plus one long hold-off to back up the pipe
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				hold_cnt <= hold_cnt + 1;
				if (hold_cnt + 1 >= HOLD_CYCLES)
					hold_done <= 1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 16);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// accept, predict, compare; watchdog on cycles with no transaction
	always @(posedge clk) begin
		curve_out_t want;
		bit out_taken;
		in_taken = in_ch.valid && in_ch.ready;
		out_taken = out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (in_taken) begin
				curve_q.push_back(map_control(in_ch.control_value));
				n_taken++;
			end
			if (out_taken) begin
				if (curve_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result mapped_value=%h saturated=%b",
						$time, out_ch.mapped_value, out_ch.saturated);
				end else begin
					want = curve_q.pop_front();
					n_checked++;
					if (want.saturated)
						n_sat++;
					if (out_ch.mapped_value !== want.mapped_value) begin
						errors++;
						$display("%0t: mapped_value expected %h actual %h",
							$time, want.mapped_value, out_ch.mapped_value);
					end
					if (out_ch.saturated !== want.saturated) begin
						errors++;
						$display("%0t: saturated expected %b actual %b",
							$time, want.saturated, out_ch.saturated);
					end
				end
			end
			if (in_taken || out_taken || (curve_q.size() == 0 && pending_q.size() == 0
					&& !in_ch.valid))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, stall_cnt);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input word_t data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_IN_BASE:  sh_in_base = data;
			REG_IN_SCALE: sh_in_scale = data;
			REG_OUT_BASE: sh_out_base = data;
			REG_OUT_SPAN: sh_out_span = data;
			REG_GAMMA:    sh_gamma = data[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_curve(input word_t ib, input word_t isc, input word_t ob,
			input word_t os, input word_t g);
		write_reg(REG_IN_BASE, ib);
		write_reg(REG_IN_SCALE, isc);
		write_reg(REG_OUT_BASE, ob);
		write_reg(REG_OUT_SPAN, os);
		write_reg(REG_GAMMA, g);
	endtask

	// all sent and all results back, then let the pipe drain fully
	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() > 0 || in_ch.valid || curve_q.size() > 0);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	initial begin
		longint v;
		fill_tables();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.control_value = '0;
		out_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset curve (identity): zero, one, fractions, negative t, field extremes
		pending_q = '{32'sd0, 32'sd65536, 32'sd32768, 32'sd1, -32'sd1, 32'sd16384,
			32'sd98304, 32'sd131072, 32'sh7FFF_FFFF, 32'sh8000_0000};
		drain();

		// steepest gamma, largest scale, negative full span: huge and tiny powers
		set_curve(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFF_FFFF);
		write_reg(REG_UNUSED, 32'h1234_5678);
		pending_q = '{32'sd0, 32'sd1, 32'sd65536, 32'sd2, 32'sh7FFF_FFFF,
			32'sh8000_0000, -32'sd65536};
		drain();

		// flattest gamma, zero span, most negative base and scale
		set_curve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
		pending_q = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0};
		drain();
		set_curve(32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 32'd1);
		pending_q = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd5};
		drain();

		// random curves; inputs mostly across the useful range of each
		for (int ph = 0; ph < 8; ph++) begin
			set_curve(
				($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'h000F_FFFF) - 32'h0008_0000,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(4096, 262144),
				($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'h00FF_FFFF) - 32'h0080_0000,
				($urandom_range(0, 3) == 0) ? $urandom
					: (($urandom_range(0, 1) == 1) ? -1 : 1) * $urandom_range(0, 32'h100_0000),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hFF_FFFF)
					: $urandom_range(32'h2000, 32'h5_0000));
			hold_req = (ph == 1);
			calm = (ph == 7);
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(0, 4) == 0 || sh_in_scale <= 0) begin
					pending_q.push_back($urandom);
				end else begin
					v = longint'(sh_in_base)
						+ (longint'($urandom_range(0, 81920)) * 65536) / longint'(sh_in_scale);
					pending_q.push_back(v[31:0]);
				end
			end
			drain();
		end

		$display("covered %0d mapped values over 12 curve settings, %0d saturated",
			n_checked, n_sat);
		$display("register extremes, stall bursts and one long output hold-off included");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
